// ----- design/sorted_index_binary_search_defines.svh -----
// Assertion macros used by the checker file
`ifndef SORTED_INDEX_BINARY_SEARCH_DEFINES_SVH
`define SORTED_INDEX_BINARY_SEARCH_DEFINES_SVH

// Same-cycle implication, sampled on the clock, off while in reset
`define SIBS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the clock, off while in reset
`define SIBS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/sibs_pkg.sv -----
`timescale 1ns / 1ps

package sibs_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = ADDR_W + 1;
   localparam int REC_W       = ADDR_W;

   // Key layout: first byte most significant, only KEY_BYTES bytes compare
   localparam int KEY_BYTES = 8;
   localparam int KEY_W     = 64;
   localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} << ((8 - KEY_BYTES) * 8);

   // One table entry: record number above the key
   localparam int ENTRY_W = REC_W + KEY_W;

   // Field widths
   localparam int CMD_W       = 2;
   localparam int STATUS_W    = 3;
   localparam int OFFSET_W    = 26;
   localparam int PROBE_W     = 4;
   localparam int SIZE_W      = 16;
   localparam int RSP_TDATA_W = 32;

   // Longest probe sequence of a full table
   localparam int PROBE_MAX = ADDR_W + 1;

   // Register reset value
   localparam logic [SIZE_W-1:0] RECORD_SIZE_RST = 16'd300;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_LOADED    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd4;

   // Comparable part of a key
   function automatic logic [KEY_W-1:0] key_part(input logic [KEY_W-1:0] k);
      key_part = k & KEY_MASK;
   endfunction

endpackage

// ----- design/sorted_index_binary_search.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Signals                              Moves
// req_      in         tvalid tready tdata tuser            one command word
// rsp_      out        tvalid tready tdata tuser            one result word
// csr_      in         valid ready data                     record size write
//
// One command at a time. Clear, full load and unknown commands go straight to the hand-off state.
// Load: each entry above the new key is read, then shifted up one, one entry at a time;
// the single RAM read port sets this.
// Search: each probe reads the midpoint entry, then compares it, at most 11 probes
// for 1024 entries.
// Reset is synchronous, active high; the table needs no clearing pass.
// A result waiting on rsp_tready holds the engine in its hand-off state only.

module sorted_index_binary_search (
   input  logic                            clock,
   input  logic                            reset,
   // slave side: tdata = key[63:0]; tuser = cmd[1:0]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [sibs_pkg::KEY_W-1:0]      req_tdata,
   input  logic [sibs_pkg::CMD_W-1:0]      req_tuser,
   // master side: tdata = offset[25:0], probes[29:26], zero [31:30]; tuser = status[2:0]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [sibs_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [sibs_pkg::STATUS_W-1:0]   rsp_tuser,
   // record size register write
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sibs_pkg::SIZE_W-1:0]     csr_data
);

   // State codes
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LD_RD  = 3'd1;
   localparam logic [2:0] S_LD_CMP = 3'd2;
   localparam logic [2:0] S_SR_RD  = 3'd3;
   localparam logic [2:0] S_SR_CMP = 3'd4;
   localparam logic [2:0] S_RESP   = 3'd5;

   logic [2:0]                        state_ff, state_in;
   logic [sibs_pkg::CNT_W-1:0]        entry_count_ff, entry_count_in;
   logic [sibs_pkg::CNT_W-1:0]        next_rec_ff, next_rec_in;
   logic [sibs_pkg::SIZE_W-1:0]       record_size_ff, record_size_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   logic [sibs_pkg::KEY_W-1:0]        key_ff, key_in;
   logic [sibs_pkg::CNT_W-1:0]        pos_ff, pos_in;
   logic [sibs_pkg::CNT_W-1:0]        low_ff, low_in;
   logic [sibs_pkg::CNT_W-1:0]        high_ff, high_in;
   logic [sibs_pkg::CNT_W-1:0]        mid_ff, mid_in;
   logic [sibs_pkg::PROBE_W-1:0]      probes_ff, probes_in;
   logic [sibs_pkg::STATUS_W-1:0]     res_status_ff, res_status_in;
   logic [sibs_pkg::OFFSET_W-1:0]     res_offset_ff, res_offset_in;
   logic [sibs_pkg::PROBE_W-1:0]      res_probes_ff, res_probes_in;
   logic [sibs_pkg::STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [sibs_pkg::OFFSET_W-1:0]     rsp_offset_ff, rsp_offset_in;
   logic [sibs_pkg::PROBE_W-1:0]      rsp_probes_ff, rsp_probes_in;

   // RAM port signals
   logic                              ram_wr_en;
   logic [sibs_pkg::ADDR_W-1:0]       ram_wr_addr;
   logic [sibs_pkg::ENTRY_W-1:0]      ram_wr_data;
   logic                              ram_rd_en;
   logic [sibs_pkg::ADDR_W-1:0]       ram_rd_addr;
   logic [sibs_pkg::ENTRY_W-1:0]      ram_rd_data;

   logic [sibs_pkg::KEY_W-1:0]        rd_key;
   logic [sibs_pkg::REC_W-1:0]        rd_rec;
   logic [sibs_pkg::CNT_W-1:0]        pos_dec;
   logic [sibs_pkg::CNT_W-1:0]        span;
   logic [sibs_pkg::CNT_W-1:0]        mid_calc;
   logic [sibs_pkg::OFFSET_W-1:0]     product;
   logic [sibs_pkg::ENTRY_W-1:0]      new_entry;
   logic                              full;

   sibs_ram #(
      .DEPTH (sibs_pkg::TABLE_DEPTH),
      .WIDTH (sibs_pkg::ENTRY_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Handshakes
   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign csr_ready  = !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(sibs_pkg::RSP_TDATA_W - sibs_pkg::OFFSET_W - sibs_pkg::PROBE_W){1'b0}},
                        rsp_probes_ff, rsp_offset_ff};

   // Entry fields and helpers
   assign rd_key    = ram_rd_data[sibs_pkg::KEY_W-1:0];
   assign rd_rec    = ram_rd_data[sibs_pkg::ENTRY_W-1:sibs_pkg::KEY_W];
   assign pos_dec   = pos_ff - sibs_pkg::CNT_W'(1);
   assign span      = high_ff - sibs_pkg::CNT_W'(1) - low_ff;
   assign mid_calc  = low_ff + (span >> 1);
   assign product   = sibs_pkg::OFFSET_W'(rd_rec) * sibs_pkg::OFFSET_W'(record_size_ff);
   assign new_entry = {next_rec_ff[sibs_pkg::REC_W-1:0], key_ff};
   assign full      = (entry_count_ff == sibs_pkg::CNT_W'(sibs_pkg::TABLE_DEPTH));

   // Sequencer: insertion shift and binary search over the RAM
   always_comb begin
      state_in       = state_ff;
      entry_count_in = entry_count_ff;
      next_rec_in    = next_rec_ff;
      record_size_in = record_size_ff;
      key_in         = key_ff;
      pos_in         = pos_ff;
      low_in         = low_ff;
      high_in        = high_ff;
      mid_in         = mid_ff;
      probes_in      = probes_ff;
      res_status_in  = res_status_ff;
      res_offset_in  = res_offset_ff;
      res_probes_in  = res_probes_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_offset_in  = rsp_offset_ff;
      rsp_probes_in  = rsp_probes_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = '0;
      ram_wr_data    = '0;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = '0;

      if (csr_valid && csr_ready) begin
         record_size_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               key_in        = req_tdata;
               probes_in     = '0;
               res_offset_in = '0;
               res_probes_in = '0;
               unique case (req_tuser)
                  sibs_pkg::CMD_LOAD: begin
                     if (full) begin
                        res_status_in = sibs_pkg::ST_FULL;
                        state_in      = S_RESP;
                     end else begin
                        pos_in   = entry_count_ff;
                        state_in = S_LD_RD;
                     end
                  end
                  sibs_pkg::CMD_SEARCH: begin
                     low_in   = '0;
                     high_in  = entry_count_ff;
                     state_in = S_SR_RD;
                  end
                  sibs_pkg::CMD_CLEAR: begin
                     entry_count_in = '0;
                     next_rec_in    = '0;
                     res_status_in  = sibs_pkg::ST_CLEARED;
                     state_in       = S_RESP;
                  end
                  default: begin
                     res_status_in = sibs_pkg::ST_NOT_FOUND;
                     state_in      = S_RESP;
                  end
               endcase
            end
         end

         // fetch the entry below the hole, or drop the key in at the bottom
         S_LD_RD: begin
            if (pos_ff == '0) begin
               ram_wr_en      = 1'b1;
               ram_wr_addr    = '0;
               ram_wr_data    = new_entry;
               entry_count_in = entry_count_ff + sibs_pkg::CNT_W'(1);
               next_rec_in    = next_rec_ff + sibs_pkg::CNT_W'(1);
               res_status_in  = sibs_pkg::ST_LOADED;
               state_in       = S_RESP;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = pos_dec[sibs_pkg::ADDR_W-1:0];
               state_in    = S_LD_CMP;
            end
         end

         // greater entry moves up one; equal keys stay ahead of the new one
         S_LD_CMP: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_ff[sibs_pkg::ADDR_W-1:0];
            if (sibs_pkg::key_part(rd_key) > sibs_pkg::key_part(key_ff)) begin
               ram_wr_data = ram_rd_data;
               pos_in      = pos_dec;
               state_in    = S_LD_RD;
            end else begin
               ram_wr_data    = new_entry;
               entry_count_in = entry_count_ff + sibs_pkg::CNT_W'(1);
               next_rec_in    = next_rec_ff + sibs_pkg::CNT_W'(1);
               res_status_in  = sibs_pkg::ST_LOADED;
               state_in       = S_RESP;
            end
         end

         // window is [low, high); probe its midpoint
         S_SR_RD: begin
            if (low_ff < high_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = mid_calc[sibs_pkg::ADDR_W-1:0];
               mid_in      = mid_calc;
               probes_in   = probes_ff + sibs_pkg::PROBE_W'(1);
               state_in    = S_SR_CMP;
            end else begin
               res_status_in = sibs_pkg::ST_NOT_FOUND;
               res_probes_in = probes_ff;
               state_in      = S_RESP;
            end
         end

         S_SR_CMP: begin
            if (sibs_pkg::key_part(key_ff) == sibs_pkg::key_part(rd_key)) begin
               res_status_in = sibs_pkg::ST_FOUND;
               res_offset_in = product;
               res_probes_in = probes_ff;
               state_in      = S_RESP;
            end else if (sibs_pkg::key_part(key_ff) < sibs_pkg::key_part(rd_key)) begin
               high_in  = mid_ff;
               state_in = S_SR_RD;
            end else begin
               low_in   = mid_ff + sibs_pkg::CNT_W'(1);
               state_in = S_SR_RD;
            end
         end

         // hand the result to the output register once it is free
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_offset_in = res_offset_ff;
               rsp_probes_in = res_probes_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         entry_count_ff <= '0;
         next_rec_ff    <= '0;
         record_size_ff <= sibs_pkg::RECORD_SIZE_RST;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         next_rec_ff    <= next_rec_in;
         record_size_ff <= record_size_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      pos_ff        <= pos_in;
      low_ff        <= low_in;
      high_ff       <= high_in;
      mid_ff        <= mid_in;
      probes_ff     <= probes_in;
      res_status_ff <= res_status_in;
      res_offset_ff <= res_offset_in;
      res_probes_ff <= res_probes_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_probes_ff <= rsp_probes_in;
   end

endmodule

// ----- design/sibs_ram.sv -----
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one registered read port
module sibs_ram #(
   parameter int DEPTH  = 1024,
   parameter int WIDTH  = 74,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- design/sibs_checker.sv -----
`timescale 1ns / 1ps
`include "sorted_index_binary_search_defines.svh"

// Port-level checks on the search engine
module sibs_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [sibs_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [sibs_pkg::STATUS_W-1:0]    rsp_tuser
);

   logic [sibs_pkg::OFFSET_W-1:0] offset;
   logic [sibs_pkg::PROBE_W-1:0]  probes;

   assign offset = rsp_tdata[sibs_pkg::OFFSET_W-1:0];
   assign probes = rsp_tdata[sibs_pkg::OFFSET_W+sibs_pkg::PROBE_W-1:sibs_pkg::OFFSET_W];

   // a stalled result word stays offered
   `SIBS_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid, "result word dropped")

   // one command in flight: the engine is busy right after taking a word
   `SIBS_ASSERT_NXT(a_one_cmd, req_tvalid && req_tready, !req_tready, "second command taken")

   // a hit took between one probe and the depth of the search tree
   `SIBS_ASSERT_IMP(a_found_probes, rsp_tvalid && rsp_tuser == sibs_pkg::ST_FOUND,
                    probes != '0 && probes <= sibs_pkg::PROBE_W'(sibs_pkg::PROBE_MAX),
                    "probe count out of range")

   // offset is only carried by a hit
   `SIBS_ASSERT_IMP(a_offset_zero, rsp_tvalid && rsp_tuser != sibs_pkg::ST_FOUND,
                    offset == '0, "offset without a hit")

   // only searches count probes
   `SIBS_ASSERT_IMP(a_probes_zero,
                    rsp_tvalid && (rsp_tuser == sibs_pkg::ST_LOADED ||
                    rsp_tuser == sibs_pkg::ST_FULL || rsp_tuser == sibs_pkg::ST_CLEARED),
                    probes == '0, "probes on a non-search result")

endmodule

bind sorted_index_binary_search sibs_checker u_sibs_checker (.*);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

// One expected reply word, fields as the result channel carries them
typedef struct packed {
   logic [sibs_pkg::STATUS_W-1:0] status;
   logic [sibs_pkg::OFFSET_W-1:0] offset;
   logic [sibs_pkg::PROBE_W-1:0]  probes;
} index_reply_type;

// Shadow of the sorted key table; predicts each reply and checks it on arrival
class key_index_tracker;
   logic [sibs_pkg::KEY_W-1:0] key_tbl [sibs_pkg::TABLE_DEPTH];
   logic [sibs_pkg::REC_W-1:0] rec_tbl [sibs_pkg::TABLE_DEPTH];
   int                         entries;
   logic [sibs_pkg::CNT_W-1:0] next_rec;
   logic [sibs_pkg::SIZE_W-1:0] rec_size;
   index_reply_type            pending_replies [$];
   int fail_count, checked, n_loads, n_full, n_search, n_hits, n_clear, n_spare;
   int max_probes;

   function new();
      entries    = 0;
      next_rec   = '0;
      rec_size   = sibs_pkg::RECORD_SIZE_RST;
      fail_count = 0;
      checked    = 0;
      n_loads    = 0;
      n_full     = 0;
      n_search   = 0;
      n_hits     = 0;
      n_clear    = 0;
      n_spare    = 0;
      max_probes = 0;
   endfunction

   // Work out the reply to one accepted command word and update the table
   function void note_command(input logic [sibs_pkg::CMD_W-1:0] cmd,
                              input logic [sibs_pkg::KEY_W-1:0] key);
      index_reply_type            r;
      int                         lo, hi, mid, pos;
      logic [sibs_pkg::KEY_W-1:0] target;
      logic [31:0]                product;
      r = '0;
      target = key & sibs_pkg::KEY_MASK;
      case (cmd)
         sibs_pkg::CMD_LOAD: begin
            n_loads++;
            if (entries >= sibs_pkg::TABLE_DEPTH) begin
               // full table: key dropped, numbering untouched
               r.status = sibs_pkg::ST_FULL;
               n_full++;
            end else begin
               // insertion sort; equal keys stay in arrival order
               pos = entries;
               while (pos > 0 && (key_tbl[pos-1] & sibs_pkg::KEY_MASK) > target) begin
                  key_tbl[pos] = key_tbl[pos-1];
                  rec_tbl[pos] = rec_tbl[pos-1];
                  pos--;
               end
               key_tbl[pos] = key;
               rec_tbl[pos] = next_rec[sibs_pkg::REC_W-1:0];
               entries++;
               next_rec = next_rec + 1'b1;
               r.status = sibs_pkg::ST_LOADED;
            end
         end
         sibs_pkg::CMD_SEARCH: begin
            n_search++;
            r.status = sibs_pkg::ST_NOT_FOUND;
            lo = 0;
            hi = entries - 1;
            while (lo <= hi && r.status != sibs_pkg::ST_FOUND) begin
               mid = lo + (hi - lo) / 2;
               r.probes = r.probes + 1'b1;
               if (target == (key_tbl[mid] & sibs_pkg::KEY_MASK)) begin
                  r.status = sibs_pkg::ST_FOUND;
                  product  = rec_tbl[mid] * rec_size;
                  r.offset = product[sibs_pkg::OFFSET_W-1:0];
               end else if (target < (key_tbl[mid] & sibs_pkg::KEY_MASK)) begin
                  hi = mid - 1;
               end else begin
                  lo = mid + 1;
               end
            end
            if (r.status == sibs_pkg::ST_FOUND) n_hits++;
            if (int'(r.probes) > max_probes) max_probes = int'(r.probes);
         end
         sibs_pkg::CMD_CLEAR: begin
            n_clear++;
            entries  = 0;
            next_rec = '0;
            r.status = sibs_pkg::ST_CLEARED;
         end
         default: begin
            // spare code: nothing changes
            n_spare++;
            r.status = sibs_pkg::ST_NOT_FOUND;
         end
      endcase
      pending_replies.push_back(r);
   endfunction

   task report(input string what);
      fail_count++;
      if (fail_count <= 40) $display("%0t ns  mismatch: %s", $time, what);
   endtask

   // Compare one accepted reply word with the oldest prediction
   task check_reply(input logic [sibs_pkg::STATUS_W-1:0] status,
                    input logic [sibs_pkg::OFFSET_W-1:0] offset,
                    input logic [sibs_pkg::PROBE_W-1:0]  probes);
      index_reply_type want;
      if (pending_replies.size() == 0) begin
         report($sformatf("reply word with nothing outstanding, status %0d", status));
      end else begin
         want = pending_replies.pop_front();
         checked++;
         if (status !== want.status)
            report($sformatf("reply %0d status %0d, predicted %0d",
                             checked, status, want.status));
         if (offset !== want.offset)
            report($sformatf("reply %0d offset %0d, predicted %0d",
                             checked, offset, want.offset));
         if (probes !== want.probes)
            report($sformatf("reply %0d probes %0d, predicted %0d",
                             checked, probes, want.probes));
      end
   endtask
endclass

module tb_top;
   import sibs_pkg::*;

   // spare command code, no meaning in the block
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
   localparam int LONG_HOLD = 300;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [KEY_W-1:0]       req_tdata = '0;
   logic [CMD_W-1:0]       req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]    rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [SIZE_W-1:0]      csr_data = '0;

   // sender and receiver idling controls, set per phase
   bit tx_gaps = 1'b1;
   bit rx_stalls = 1'b1;
   int hold_requests = 0;

   key_index_tracker tracker = new();

   sorted_index_binary_search u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   // Hard stop
   initial begin
      #4_000_000;
      $display("FAIL");
      $finish;
   end

   // Idle length before a word: mostly none or short, now and then long
   function automatic int pick_gap(input bit enabled);
      int r;
      r = $urandom_range(99);
      if (!enabled || r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 4);
   endfunction

   // Random key; some look like short text padded with zero bytes
   function automatic logic [KEY_W-1:0] random_key();
      logic [KEY_W-1:0] k;
      logic [7:0]       ch;
      int               len;
      k = {$urandom, $urandom};
      if ($urandom_range(9) < 3) begin
         len = $urandom_range(8, 1);
         for (int b = 0; b < 8; b++) begin
            ch = 8'($urandom_range(126, 32));
            k[63-8*b -: 8] = (b < len) ? ch : 8'h00;
         end
      end
      return k;
   endfunction

   // Key already held in the table, or a random one if it is empty
   function automatic logic [KEY_W-1:0] held_key();
      if (tracker.entries == 0) return random_key();
      return tracker.key_tbl[$urandom_range(tracker.entries - 1)];
   endfunction

   // Offer one command word and wait for it to be taken
   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key);
      int gap;
      gap = pick_gap(tx_gaps);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= key;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.note_command(cmd, key);
   endtask

   // Stop offering and wait for every outstanding reply
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (tracker.pending_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Record size write, only with the block idle
   task automatic write_record_size(input logic [SIZE_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.rec_size = value;
      csr_valid <= 1'b0;
   endtask

   // Small table work: loads, searches, clears and spare codes over a key pool
   task automatic run_mixed_phase(input int n_items, input int pool_size, input int cap);
      logic [KEY_W-1:0] pool [$];
      logic [KEY_W-1:0] key;
      logic [CMD_W-1:0] cmd;
      int               r;
      pool.delete();
      repeat (pool_size) pool.push_back(random_key());
      repeat (n_items) begin
         r = $urandom_range(99);
         if (r < 4) cmd = CMD_SPARE;
         else if (r < 10) cmd = CMD_CLEAR;
         else if (r < 55 && tracker.entries < cap) cmd = CMD_LOAD;
         else cmd = CMD_SEARCH;
         r = $urandom_range(99);
         if (r < 60) key = pool[$urandom_range(pool.size() - 1)];
         else if (r < 80) key = held_key();
         else key = random_key();
         send_word(cmd, key);
      end
   endtask

   // Fill the table to the top, mostly appending, then push past full
   task automatic run_fill_phase();
      logic [KEY_W-1:0] climb, key;
      int               r;
      send_word(CMD_CLEAR, random_key());
      climb = {$urandom, $urandom};
      climb[63:62] = 2'b10;
      while (tracker.entries < TABLE_DEPTH) begin
         r = $urandom_range(99);
         if (r < 8) begin
            send_word(CMD_SEARCH, (r < 6) ? held_key() : random_key());
         end else if (r < 12) begin
            // equal key somewhere in the middle: shifts part of the table
            send_word(CMD_LOAD, held_key());
         end else if (r < 14) begin
            // below every ascending key: shifts most of the table
            key = random_key();
            key[63] = 1'b0;
            send_word(CMD_LOAD, key);
         end else begin
            climb = climb + {$urandom_range(1000, 1), $urandom};
            send_word(CMD_LOAD, climb);
         end
      end
      // loads into a full table are refused
      send_word(CMD_LOAD, '0);
      send_word(CMD_LOAD, '1);
      repeat (4) send_word(CMD_LOAD, random_key());
      // searches over the full table, both ends included
      send_word(CMD_SEARCH, tracker.key_tbl[0]);
      send_word(CMD_SEARCH, tracker.key_tbl[TABLE_DEPTH-1]);
      repeat (38) send_word(CMD_SEARCH, ($urandom_range(3) != 0) ? held_key() : random_key());
   endtask

   // Result side: check every accepted word, stall at random, hold off on request
   initial begin : reply_sink
      int  seg_left, hold_left, served;
      bit  seg_ready;
      seg_left  = 0;
      hold_left = 0;
      served    = 0;
      seg_ready = 1'b1;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            tracker.check_reply(rsp_tuser, rsp_tdata[OFFSET_W-1:0],
                                rsp_tdata[OFFSET_W +: PROBE_W]);
         if (served != hold_requests) begin
            served    = hold_requests;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (seg_left == 0) begin
               seg_ready = !rx_stalls || $urandom_range(1);
               if (seg_ready) seg_left = $urandom_range(30, 1);
               else if ($urandom_range(99) < 85) seg_left = $urandom_range(3, 1);
               else seg_left = $urandom_range(60, 10);
            end
            seg_left--;
            rsp_tready <= seg_ready;
         end
      end
   end

   // Stimulus
   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, key extremes, equal keys, spare code, clear
      send_word(CMD_SEARCH, '0);
      send_word(CMD_SPARE, '1);
      send_word(CMD_LOAD, '0);
      send_word(CMD_LOAD, '1);
      send_word(CMD_LOAD, 64'h414C_5048_4100_0000);
      send_word(CMD_LOAD, 64'h414C_5048_4100_0000);
      send_word(CMD_LOAD, 64'h8000_0000_0000_0000);
      send_word(CMD_LOAD, 64'h7FFF_FFFF_FFFF_FFFF);
      send_word(CMD_LOAD, 64'h414C_5048_4100_0000);
      send_word(CMD_SEARCH, '0);
      send_word(CMD_SEARCH, '1);
      send_word(CMD_SEARCH, 64'h414C_5048_4100_0000);
      send_word(CMD_SEARCH, 64'h8000_0000_0000_0000);
      send_word(CMD_SEARCH, 64'h7FFF_FFFF_FFFF_FFFF);
      send_word(CMD_SEARCH, 64'h0000_0000_0000_0001);
      send_word(CMD_SEARCH, 64'hFFFF_FFFF_FFFF_FFFE);
      send_word(CMD_SPARE, '0);
      send_word(CMD_CLEAR, '0);
      send_word(CMD_SEARCH, 64'h414C_5048_4100_0000);
      send_word(CMD_LOAD, 64'h414C_5048_4100_0000);
      send_word(CMD_SEARCH, 64'h414C_5048_4100_0000);
      send_word(CMD_CLEAR, '1);
      wait_drained();

      // smallest record size, dense duplicates
      write_record_size(16'd1);
      run_mixed_phase(60, 12, 40);
      wait_drained();

      // largest record size, no sender gaps, receiver holds off long enough to back up
      write_record_size(16'hFFFF);
      tx_gaps = 1'b0;
      hold_requests++;
      run_mixed_phase(60, 30, 64);
      wait_drained();

      // random size, very few distinct keys, no idling on either side
      write_record_size(SIZE_W'($urandom_range(65534, 2)));
      rx_stalls = 1'b0;
      run_mixed_phase(50, 6, 200);
      wait_drained();

      // full table with the largest offsets
      write_record_size(16'hFFFF);
      tx_gaps   = 1'b1;
      rx_stalls = 1'b1;
      run_fill_phase();
      wait_drained();

      // back to the reset size, then a fresh start
      write_record_size(RECORD_SIZE_RST);
      send_word(CMD_CLEAR, '0);
      run_mixed_phase(40, 10, 30);

      // drain, then allow for a stray late word
      req_tvalid <= 1'b0;
      for (int i = 0; i < 100000 && tracker.pending_replies.size() != 0; i++)
         @(posedge clock);
      repeat (60) @(posedge clock);
      if (tracker.pending_replies.size() != 0)
         tracker.report($sformatf("%0d replies never arrived",
                                  tracker.pending_replies.size()));

      $display("covered %0d words: %0d loads (%0d refused on a full table), %0d searches",
               tracker.checked, tracker.n_loads, tracker.n_full, tracker.n_search);
      $display("  %0d hits, up to %0d probes, %0d clears, %0d spare codes, sizes 1 to 65535",
               tracker.n_hits, tracker.max_probes, tracker.n_clear, tracker.n_spare);
      if (tracker.fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
